### hdl/ecd_pkg.sv
`default_nettype none
package ecd_pkg;

   localparam int EPOCH_W   = 32;
   localparam int OPND_W    = 18;   // width of the shared compare/subtract unit
   localparam int REM_W     = 17;   // running remainder of the time-of-day split
   localparam int DAYS_W    = 16;   // whole days since epoch, max 49710
   localparam int YEAR_W    = 12;
   localparam int MONTH_W   = 4;
   localparam int MDAY_W    = 5;
   localparam int WDAY_W    = 3;
   localparam int HOUR_W    = 5;
   localparam int MIN_W     = 6;
   localparam int SEC_W     = 6;

   // shared multiplier
   localparam int MUL_A_W   = 25;
   localparam int MUL_B_W   = 26;
   localparam int PROD_W    = 51;

   // floor(x / d) == (x * RCP) >> shift for every x of the noted width
   localparam logic [MUL_B_W-1:0] RCP_DAY   = 26'd50903317;   // 25-bit x / 675, shift 35
   localparam logic [MUL_B_W-1:0] DAY_DIV   = 26'd675;        // 86400 >> 7
   localparam logic [MUL_B_W-1:0] RCP_HOUR  = 26'd9321;       // 13-bit x / 225, shift 21
   localparam logic [MUL_B_W-1:0] HOUR_DIV  = 26'd225;        // 3600 >> 4
   localparam logic [MUL_B_W-1:0] RCP_MIN   = 26'd1093;       // 10-bit x / 15, shift 14
   localparam logic [MUL_B_W-1:0] MIN_DIV   = 26'd15;         // 60 >> 2
   localparam logic [MUL_B_W-1:0] RCP_WDAY  = 26'd74899;      // 16-bit x / 7, shift 19
   localparam logic [MUL_B_W-1:0] WDAY_DIV  = 26'd7;

   localparam logic [REM_W-1:0]   EPOCH_WDAY   = 17'd4;   // 1970-01-01 was a Thursday

   localparam logic [YEAR_W-1:0]  EPOCH_YEAR   = 12'd1970;
   localparam logic [6:0]         EPOCH_MOD100 = 7'd70;
   localparam logic [8:0]         EPOCH_MOD400 = 9'd370;
   localparam logic [6:0]         LAST_MOD100  = 7'd99;
   localparam logic [8:0]         LAST_MOD400  = 9'd399;

   localparam logic [OPND_W-1:0]  YEAR_DAYS    = 18'd365;
   localparam logic [OPND_W-1:0]  LEAP_DAYS    = 18'd366;

   localparam logic [MONTH_W-1:0] MONTH_JAN    = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC    = 4'd12;

   typedef struct packed {
      logic init;   // load the epoch year
      logic step;   // advance one year
   } leap_ctl_type;

   function automatic logic [OPND_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
      logic [OPND_W-1:0] len;
      case (month)
         MONTH_FEB:                  len = leap ? 18'd29 : 18'd28;
         4'd4, 4'd6, 4'd9, 4'd11:    len = 18'd30;
         default:                    len = 18'd31;
      endcase
      return len;
   endfunction

endpackage
`default_nettype wire

### hdl/ecd_cmp_sub.sv
`default_nettype none
module ecd_cmp_sub (
   input  wire logic [ecd_pkg::OPND_W-1:0] a,
   input  wire logic [ecd_pkg::OPND_W-1:0] b,
   output logic      [ecd_pkg::OPND_W-1:0] diff,
   output logic                            ge
);

   logic [ecd_pkg::OPND_W:0] wide;

   // borrow out of the extended subtract is the compare result
   assign wide = {1'b0, a} - {1'b0, b};
   assign diff = wide[ecd_pkg::OPND_W-1:0];
   assign ge   = ~wide[ecd_pkg::OPND_W];

endmodule
`default_nettype wire

### hdl/ecd_leap_ctr.sv
`default_nettype none
module ecd_leap_ctr (
   input  wire logic                          clock,
   input  wire ecd_pkg::leap_ctl_type         ctl,
   output logic      [ecd_pkg::YEAR_W-1:0]    year,
   output logic                               leap
);

   logic [ecd_pkg::YEAR_W-1:0] year_ff, year_in;
   logic [6:0]                 mod100_ff, mod100_in;
   logic [8:0]                 mod400_ff, mod400_in;

   always_comb begin
      year_in   = year_ff;
      mod100_in = mod100_ff;
      mod400_in = mod400_ff;
      if (ctl.init) begin
         year_in   = ecd_pkg::EPOCH_YEAR;
         mod100_in = ecd_pkg::EPOCH_MOD100;
         mod400_in = ecd_pkg::EPOCH_MOD400;
      end else if (ctl.step) begin
         year_in   = year_ff + 12'd1;
         mod100_in = (mod100_ff == ecd_pkg::LAST_MOD100) ? 7'd0 : mod100_ff + 7'd1;
         mod400_in = (mod400_ff == ecd_pkg::LAST_MOD400) ? 9'd0 : mod400_ff + 9'd1;
      end
   end

   always_ff @(posedge clock) begin
      year_ff   <= year_in;
      mod100_ff <= mod100_in;
      mod400_ff <= mod400_in;
   end

   assign year = year_ff;
   assign leap = (year_ff[1:0] == 2'd0) && ((mod100_ff != 7'd0) || (mod400_ff == 9'd0));

endmodule
`default_nettype wire

### hdl/epoch_to_calendar_date_top.sv
// Converts a 32-bit unsigned Unix time to Gregorian date, time of day and weekday
// (0 = Sunday). One item is in work at a time; req_ready is low while it is.
// Days, hours, minutes and the weekday come from reciprocal multiplies on one
// shared multiplier, each followed by a back-multiply and subtract on the shared
// 18-bit compare/subtract unit. The year is then found by subtracting whole
// years from 1970 and the month by subtracting whole months, up to December.
// The result sits in an output register, so a new item is taken while it waits.
`default_nettype none
module epoch_to_calendar_date_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [ecd_pkg::EPOCH_W-1:0]     req_epoch_seconds,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [ecd_pkg::YEAR_W-1:0]      rsp_year,
   output logic      [ecd_pkg::MONTH_W-1:0]     rsp_month,
   output logic      [ecd_pkg::MDAY_W-1:0]      rsp_day_of_month,
   output logic      [ecd_pkg::WDAY_W-1:0]      rsp_weekday,
   output logic      [ecd_pkg::HOUR_W-1:0]      rsp_hour,
   output logic      [ecd_pkg::MIN_W-1:0]       rsp_minute,
   output logic      [ecd_pkg::SEC_W-1:0]       rsp_second
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_DAY_Q  = 4'd1;
   localparam logic [3:0] ST_DAY_R  = 4'd2;
   localparam logic [3:0] ST_HOUR_Q = 4'd3;
   localparam logic [3:0] ST_HOUR_R = 4'd4;
   localparam logic [3:0] ST_MIN_Q  = 4'd5;
   localparam logic [3:0] ST_MIN_R  = 4'd6;
   localparam logic [3:0] ST_WDAY_Q = 4'd7;
   localparam logic [3:0] ST_WDAY_R = 4'd8;
   localparam logic [3:0] ST_YEAR   = 4'd9;
   localparam logic [3:0] ST_MONTH  = 4'd10;
   localparam logic [3:0] ST_DONE   = 4'd11;

   logic [3:0]                      state_ff, state_in;
   logic [ecd_pkg::EPOCH_W-1:0]     num_ff, num_in;
   logic [ecd_pkg::REM_W-1:0]       rem_ff, rem_in;
   logic [ecd_pkg::DAYS_W-1:0]      days_ff, days_in;
   logic [ecd_pkg::MONTH_W-1:0]     month_ff, month_in;
   logic [ecd_pkg::HOUR_W-1:0]      hour_ff, hour_in;
   logic [ecd_pkg::MIN_W-1:0]       minute_ff, minute_in;
   logic [ecd_pkg::SEC_W-1:0]       second_ff, second_in;
   logic [ecd_pkg::WDAY_W-1:0]      weekday_ff, weekday_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ecd_pkg::YEAR_W-1:0]      rsp_year_ff;
   logic [ecd_pkg::MONTH_W-1:0]     rsp_month_ff;
   logic [ecd_pkg::MDAY_W-1:0]      rsp_mday_ff;
   logic [ecd_pkg::WDAY_W-1:0]      rsp_wday_ff;
   logic [ecd_pkg::HOUR_W-1:0]      rsp_hour_ff;
   logic [ecd_pkg::MIN_W-1:0]       rsp_min_ff;
   logic [ecd_pkg::SEC_W-1:0]       rsp_sec_ff;

   logic [ecd_pkg::OPND_W-1:0]      op_a, op_b, diff;
   logic                            ge;
   logic [ecd_pkg::MUL_A_W-1:0]     mul_a;
   logic [ecd_pkg::MUL_B_W-1:0]     mul_b;
   logic [ecd_pkg::PROD_W-1:0]      prod;
   logic [ecd_pkg::REM_W-1:0]       wday_dividend;
   logic                            load_out;
   logic [ecd_pkg::YEAR_W-1:0]      year;
   logic                            leap;
   ecd_pkg::leap_ctl_type           leap_ctl;

   assign wday_dividend = {1'b0, days_ff} + ecd_pkg::EPOCH_WDAY;
   assign load_out = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // shared multiplier: quotient by reciprocal in the _Q states,
   // quotient times divisor in the _R states
   always_comb begin
      case (state_ff)
         ST_DAY_Q: begin
            mul_a = num_ff[31:7];
            mul_b = ecd_pkg::RCP_DAY;
         end
         ST_DAY_R: begin
            mul_a = {9'd0, days_ff};
            mul_b = ecd_pkg::DAY_DIV;
         end
         ST_HOUR_Q: begin
            mul_a = {12'd0, rem_ff[16:4]};
            mul_b = ecd_pkg::RCP_HOUR;
         end
         ST_HOUR_R: begin
            mul_a = {20'd0, hour_ff};
            mul_b = ecd_pkg::HOUR_DIV;
         end
         ST_MIN_Q: begin
            mul_a = {15'd0, rem_ff[11:2]};
            mul_b = ecd_pkg::RCP_MIN;
         end
         ST_MIN_R: begin
            mul_a = {19'd0, minute_ff};
            mul_b = ecd_pkg::MIN_DIV;
         end
         ST_WDAY_Q: begin
            mul_a = {8'd0, wday_dividend};
            mul_b = ecd_pkg::RCP_WDAY;
         end
         ST_WDAY_R: begin
            mul_a = {8'd0, rem_ff};
            mul_b = ecd_pkg::WDAY_DIV;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = {{(ecd_pkg::PROD_W-ecd_pkg::MUL_A_W){1'b0}}, mul_a} *
                 {{(ecd_pkg::PROD_W-ecd_pkg::MUL_B_W){1'b0}}, mul_b};

   // remainders are below 2^18, so the low operand bits are enough
   always_comb begin
      case (state_ff)
         ST_DAY_R: begin
            op_a = num_ff[24:7];
            op_b = prod[ecd_pkg::OPND_W-1:0];
         end
         ST_HOUR_R: begin
            op_a = {5'd0, rem_ff[16:4]};
            op_b = prod[ecd_pkg::OPND_W-1:0];
         end
         ST_MIN_R: begin
            op_a = {8'd0, rem_ff[11:2]};
            op_b = prod[ecd_pkg::OPND_W-1:0];
         end
         ST_WDAY_R: begin
            op_a = {1'b0, wday_dividend};
            op_b = prod[ecd_pkg::OPND_W-1:0];
         end
         ST_YEAR: begin
            op_a = {2'b00, days_ff};
            op_b = leap ? ecd_pkg::LEAP_DAYS : ecd_pkg::YEAR_DAYS;
         end
         ST_MONTH: begin
            op_a = {2'b00, days_ff};
            op_b = ecd_pkg::month_days(month_ff, leap);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   ecd_cmp_sub u_cmp_sub (
      .a    (op_a),
      .b    (op_b),
      .diff (diff),
      .ge   (ge)
   );

   assign leap_ctl.init = (state_ff == ST_WDAY_R);
   assign leap_ctl.step = (state_ff == ST_YEAR) && ge;

   ecd_leap_ctr u_leap_ctr (
      .clock (clock),
      .ctl   (leap_ctl),
      .year  (year),
      .leap  (leap)
   );

   always_comb begin
      state_in   = state_ff;
      num_in     = num_ff;
      rem_in     = rem_ff;
      days_in    = days_ff;
      month_in   = month_ff;
      hour_in    = hour_ff;
      minute_in  = minute_ff;
      second_in  = second_ff;
      weekday_in = weekday_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               num_in   = req_epoch_seconds;
               state_in = ST_DAY_Q;
            end
         end
         ST_DAY_Q: begin
            days_in  = prod[50:35];
            state_in = ST_DAY_R;
         end
         ST_DAY_R: begin
            rem_in   = {diff[9:0], num_ff[6:0]};
            state_in = ST_HOUR_Q;
         end
         ST_HOUR_Q: begin
            hour_in  = prod[25:21];
            state_in = ST_HOUR_R;
         end
         ST_HOUR_R: begin
            rem_in   = {5'd0, diff[7:0], rem_ff[3:0]};
            state_in = ST_MIN_Q;
         end
         ST_MIN_Q: begin
            minute_in = prod[19:14];
            state_in  = ST_MIN_R;
         end
         ST_MIN_R: begin
            second_in = {diff[3:0], rem_ff[1:0]};
            state_in  = ST_WDAY_Q;
         end
         ST_WDAY_Q: begin
            // quotient of (days + 4) / 7 parks in the remainder register
            rem_in   = {4'd0, prod[31:19]};
            state_in = ST_WDAY_R;
         end
         ST_WDAY_R: begin
            weekday_in = diff[ecd_pkg::WDAY_W-1:0];
            state_in   = ST_YEAR;
         end
         ST_YEAR: begin
            if (ge) begin
               days_in = diff[ecd_pkg::DAYS_W-1:0];
            end else begin
               month_in = ecd_pkg::MONTH_JAN;
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            if (ge && (month_ff != ecd_pkg::MONTH_DEC)) begin
               days_in  = diff[ecd_pkg::DAYS_W-1:0];
               month_in = month_ff + 4'd1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff     <= num_in;
      rem_ff     <= rem_in;
      days_ff    <= days_in;
      month_ff   <= month_in;
      hour_ff    <= hour_in;
      minute_ff  <= minute_in;
      second_ff  <= second_in;
      weekday_ff <= weekday_in;
      if (load_out) begin
         rsp_year_ff  <= year;
         rsp_month_ff <= month_ff;
         rsp_mday_ff  <= days_ff[ecd_pkg::MDAY_W-1:0] + 5'd1;
         rsp_wday_ff  <= weekday_ff;
         rsp_hour_ff  <= hour_ff;
         rsp_min_ff   <= minute_ff;
         rsp_sec_ff   <= second_ff;
      end
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_year         = rsp_year_ff;
   assign rsp_month        = rsp_month_ff;
   assign rsp_day_of_month = rsp_mday_ff;
   assign rsp_weekday      = rsp_wday_ff;
   assign rsp_hour         = rsp_hour_ff;
   assign rsp_minute       = rsp_min_ff;
   assign rsp_second       = rsp_sec_ff;

   // once years are stripped, fewer than a year's days remain
   a_month_days_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MONTH) |-> (days_ff <= 16'd365))
      else $error("day count too large in month search");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> ((month_ff >= ecd_pkg::MONTH_JAN) &&
                                 (month_ff <= ecd_pkg::MONTH_DEC)))
      else $error("month out of range at completion");

   a_year_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MONTH) |-> (year <= 12'd2106))
      else $error("year search ran past 2106");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised without a completed item");

endmodule
`default_nettype wire
